/* hdl/hgp_pkg.sv */
package hgp_pkg;

    // Width of the max_request_bytes configuration register.
    localparam int CFG_W = 16;
    // Width of the parsed body length.
    localparam int LEN_W = 31;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // Result status codes.
    localparam logic [1:0] ST_PENDING  = 2'd0;
    localparam logic [1:0] ST_COMPLETE = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    // Character codes.
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_T     = 8'h74;

    // Match positions of special meaning while the URL is parsed.
    localparam logic [4:0] URL_SEEK = 5'd7;
    localparam logic [4:0] URL_PATH = 5'd8;

    // Match lengths.
    localparam logic [4:0] LEN_GET  = 5'd3;
    localparam logic [4:0] LEN_VER  = 5'd8;
    localparam logic [4:0] LEN_ABS  = 5'd7;
    localparam logic [4:0] LEN_CON  = 5'd3;
    localparam logic [4:0] LEN_CONN = 5'd11;
    localparam logic [4:0] LEN_CLEN = 5'd15;
    localparam logic [4:0] LEN_KEEP = 5'd10;

    typedef enum logic [2:0] {
        PH_METHOD  = 3'd0,
        PH_URL     = 3'd1,
        PH_VERSION = 3'd2,
        PH_NAME    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_BODY    = 3'd5,
        PH_DONE    = 3'd6,
        PH_BAD     = 3'd7
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_CONN = 2'd1,
        KIND_CLEN = 2'd2,
        KIND_BOTH = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_request;
    } item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             url_byte_valid;
        logic             keep_alive;
        logic [LEN_W-1:0] content_length;
    } result_t;

    function automatic logic [7:0] lower_of(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] get_char(input logic [3:0] i);
        unique case (i)
            4'd0:    return "g";
            4'd1:    return "e";
            4'd2:    return "t";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] ver_char(input logic [3:0] i);
        unique case (i)
            4'd0:    return "h";
            4'd1:    return "t";
            4'd2:    return "t";
            4'd3:    return "p";
            4'd4:    return "/";
            4'd5:    return "1";
            4'd6:    return ".";
            4'd7:    return "1";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] abs_char(input logic [3:0] i);
        unique case (i)
            4'd0:    return "h";
            4'd1:    return "t";
            4'd2:    return "t";
            4'd3:    return "p";
            4'd4:    return ":";
            4'd5:    return "/";
            4'd6:    return "/";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] conn_char(input logic [3:0] i);
        unique case (i)
            4'd0:    return "c";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "n";
            4'd4:    return "e";
            4'd5:    return "c";
            4'd6:    return "t";
            4'd7:    return "i";
            4'd8:    return "o";
            4'd9:    return "n";
            4'd10:   return ":";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] clen_char(input logic [3:0] i);
        unique case (i)
            4'd0:    return "c";
            4'd1:    return "o";
            4'd2:    return "n";
            4'd3:    return "t";
            4'd4:    return "e";
            4'd5:    return "n";
            4'd6:    return "t";
            4'd7:    return "-";
            4'd8:    return "l";
            4'd9:    return "e";
            4'd10:   return "n";
            4'd11:   return "g";
            4'd12:   return "t";
            4'd13:   return "h";
            4'd14:   return ":";
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] keep_char(input logic [3:0] i);
        unique case (i)
            4'd0:    return "k";
            4'd1:    return "e";
            4'd2:    return "e";
            4'd3:    return "p";
            4'd4:    return "-";
            4'd5:    return "a";
            4'd6:    return "l";
            4'd7:    return "i";
            4'd8:    return "v";
            4'd9:    return "e";
            default: return 8'h00;
        endcase
    endfunction

endpackage

/* hdl/hgp_ifs.sv */
// Request byte channel.
interface hgp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_request;

    modport source (output valid, output data_byte, output start_of_request, input ready);
    modport sink   (input valid, input data_byte, input start_of_request, output ready);
endinterface

// Parse result channel.
interface hgp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        url_byte_valid;
    logic        keep_alive;
    logic [30:0] content_length;

    modport source (output valid, output status, output url_byte_valid, output keep_alive,
                    output content_length, input ready);
    modport sink   (input valid, input status, input url_byte_valid, input keep_alive,
                    input content_length, output ready);
endinterface

/* hdl/hgp_in_reg.sv */
module hgp_in_reg
    import hgp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    hgp_in_if.sink  in_item,
    input  logic    take,
    output logic    valid,
    output item_t   item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // The register may refill in the same cycle it hands its item on.
    assign in_item.ready = !valid_reg || take;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_item.ready)
        begin
            valid_next = in_item.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_item.valid && in_item.ready)
        begin
            item_reg <= '{data_byte: in_item.data_byte,
                          start_of_request: in_item.start_of_request};
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

/* hdl/hgp_parse.sv */
module hgp_parse
    import hgp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data,
    input  logic             step,
    input  item_t            item,
    output result_t          result
);

    localparam int LW = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
    localparam logic [LW-1:0] CMASK = {LW{1'b1}} >> (LW - COUNT_WIDTH);

    logic [CFG_W-1:0]       max_bytes_reg;
    phase_t                 phase_reg,  phase_next;
    logic                   cr_reg,     cr_next;
    logic [4:0]             mp_reg,     mp_next;
    kind_t                  kind_reg,   kind_next;
    logic                   empty_reg,  empty_next;
    logic [LEN_W-1:0]       len_reg,    len_next;
    logic [LEN_W-1:0]       body_reg,   body_next;
    logic                   keep_reg,   keep_next;
    logic [COUNT_WIDTH-1:0] rcv_reg,    rcv_next;

    logic [LW-1:0]    limit;
    logic [LW-1:0]    mrb_ext;
    logic [7:0]       b;
    logic [7:0]       lo;
    logic [4:0]       k;
    logic [LEN_W+3:0] prod;
    logic [1:0]       status;
    logic             url;

    assign mrb_ext = LW'(max_bytes_reg);
    assign limit   = (mrb_ext > CMASK) ? CMASK : mrb_ext;
    assign b       = item.data_byte;
    assign lo      = lower_of(item.data_byte);

    always_comb
    begin
        phase_next = phase_reg;
        cr_next    = cr_reg;
        mp_next    = mp_reg;
        kind_next  = kind_reg;
        empty_next = empty_reg;
        len_next   = len_reg;
        body_next  = body_reg;
        keep_next  = keep_reg;
        rcv_next   = rcv_reg;
        status     = ST_PENDING;
        url        = 1'b0;
        k          = '0;
        prod       = '0;

        if (item.start_of_request)
        begin
            phase_next = PH_METHOD;
            cr_next    = 1'b0;
            mp_next    = '0;
            kind_next  = KIND_BOTH;
            empty_next = 1'b1;
            len_next   = '0;
            body_next  = '0;
            keep_next  = 1'b0;
            rcv_next   = '0;
        end

        if (phase_next == PH_DONE)
        begin
            status = ST_COMPLETE;
        end
        else if (phase_next == PH_BAD)
        begin
            status = ST_BAD;
        end
        else if (LW'(rcv_next) >= limit)
        begin
            status = ST_TOO_LONG;
        end
        else
        begin
            rcv_next = rcv_next + COUNT_WIDTH'(1);
            if (phase_next == PH_BODY)
            begin
                body_next = body_next + LEN_W'(1);
                if (body_next >= len_next)
                begin
                    phase_next = PH_DONE;
                    status     = ST_COMPLETE;
                end
            end
            else if (cr_next)
            begin
                cr_next = 1'b0;
                if (b != CH_LF)
                begin
                    phase_next = PH_BAD;
                    status     = ST_BAD;
                end
                else
                begin
                    unique case (phase_next)
                        PH_VERSION:
                        begin
                            if (mp_next == LEN_VER)
                            begin
                                phase_next = PH_NAME;
                                mp_next    = '0;
                                kind_next  = KIND_BOTH;
                                empty_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_BAD;
                                status     = ST_BAD;
                            end
                        end
                        PH_NAME:
                        begin
                            if (!empty_next)
                            begin
                                mp_next    = '0;
                                kind_next  = KIND_BOTH;
                                empty_next = 1'b1;
                            end
                            else if (len_next != '0)
                            begin
                                phase_next = PH_BODY;
                                body_next  = '0;
                            end
                            else
                            begin
                                phase_next = PH_DONE;
                                status     = ST_COMPLETE;
                            end
                        end
                        PH_VALUE:
                        begin
                            if (kind_next == KIND_CONN && mp_next == LEN_CONN)
                            begin
                                keep_next = 1'b1;
                            end
                            phase_next = PH_NAME;
                            mp_next    = '0;
                            kind_next  = KIND_BOTH;
                            empty_next = 1'b1;
                        end
                        default:
                        begin
                            phase_next = PH_BAD;
                            status     = ST_BAD;
                        end
                    endcase
                end
            end
            else if (b == CH_LF)
            begin
                phase_next = PH_BAD;
                status     = ST_BAD;
            end
            else if (b == CH_CR)
            begin
                cr_next = 1'b1;
            end
            else
            begin
                unique case (phase_next)
                    PH_METHOD:
                    begin
                        if (mp_next < LEN_GET && lo == get_char(mp_next[3:0]))
                        begin
                            mp_next = mp_next + 5'd1;
                        end
                        else if (mp_next == LEN_GET && b == CH_SP)
                        begin
                            phase_next = PH_URL;
                            mp_next    = '0;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                            status     = ST_BAD;
                        end
                    end
                    PH_URL:
                    begin
                        if (b == CH_SP)
                        begin
                            if (mp_next == URL_PATH)
                            begin
                                phase_next = PH_VERSION;
                                mp_next    = '0;
                            end
                            else
                            begin
                                phase_next = PH_BAD;
                                status     = ST_BAD;
                            end
                        end
                        else if (mp_next == URL_PATH)
                        begin
                            url = 1'b1;
                        end
                        else if (mp_next == URL_SEEK)
                        begin
                            // Skipping the authority of an absolute URL.
                            if (b == CH_SLASH)
                            begin
                                mp_next = URL_PATH;
                                url     = 1'b1;
                            end
                        end
                        else if (mp_next == '0 && b == CH_SLASH)
                        begin
                            mp_next = URL_PATH;
                            url     = 1'b1;
                        end
                        else if (mp_next < LEN_ABS && lo == abs_char(mp_next[3:0]))
                        begin
                            mp_next = mp_next + 5'd1;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                            status     = ST_BAD;
                        end
                    end
                    PH_VERSION:
                    begin
                        if (mp_next < LEN_VER && lo == ver_char(mp_next[3:0]))
                        begin
                            mp_next = mp_next + 5'd1;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                            status     = ST_BAD;
                        end
                    end
                    PH_NAME:
                    begin
                        empty_next = 1'b0;
                        unique case (kind_next)
                            KIND_BOTH:
                            begin
                                if (mp_next < LEN_CON && lo == conn_char(mp_next[3:0]))
                                begin
                                    mp_next = mp_next + 5'd1;
                                end
                                else if (mp_next == LEN_CON && lo == CH_N)
                                begin
                                    kind_next = KIND_CONN;
                                    mp_next   = LEN_CON + 5'd1;
                                end
                                else if (mp_next == LEN_CON && lo == CH_T)
                                begin
                                    kind_next = KIND_CLEN;
                                    mp_next   = LEN_CON + 5'd1;
                                end
                                else
                                begin
                                    kind_next = KIND_NONE;
                                end
                            end
                            KIND_CONN:
                            begin
                                if (mp_next < LEN_CONN && lo == conn_char(mp_next[3:0]))
                                begin
                                    mp_next = mp_next + 5'd1;
                                    if (mp_next == LEN_CONN)
                                    begin
                                        phase_next = PH_VALUE;
                                        mp_next    = '0;
                                    end
                                end
                                else
                                begin
                                    kind_next = KIND_NONE;
                                end
                            end
                            KIND_CLEN:
                            begin
                                if (mp_next < LEN_CLEN && lo == clen_char(mp_next[3:0]))
                                begin
                                    mp_next = mp_next + 5'd1;
                                    if (mp_next == LEN_CLEN)
                                    begin
                                        phase_next = PH_VALUE;
                                        mp_next    = '0;
                                        len_next   = '0;
                                    end
                                end
                                else
                                begin
                                    kind_next = KIND_NONE;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                    default:
                    begin
                        // Header value. Position zero still skips leading blanks.
                        if (!(mp_next == '0 && (b == CH_SP || b == CH_TAB)))
                        begin
                            if (kind_next == KIND_CONN)
                            begin
                                k = (mp_next == '0) ? 5'd0 : mp_next - 5'd1;
                                if (k < LEN_KEEP && lo == keep_char(k[3:0]))
                                begin
                                    mp_next = k + 5'd2;
                                end
                                else
                                begin
                                    kind_next = KIND_NONE;
                                end
                            end
                            else if (kind_next == KIND_CLEN)
                            begin
                                if (b >= CH_0 && b <= CH_9)
                                begin
                                    prod = (LEN_W+4)'({len_next, 3'b000})
                                         + (LEN_W+4)'({len_next, 1'b0})
                                         + (LEN_W+4)'(b[3:0]);
                                    len_next = (prod > (LEN_W+4)'(LEN_MAX)) ? LEN_MAX
                                                                             : prod[LEN_W-1:0];
                                    mp_next = 5'd1;
                                end
                                else
                                begin
                                    kind_next = KIND_NONE;
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_bytes_reg <= CFG_W'(2048);
        end
        else if (cfg_write_en)
        begin
            max_bytes_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_METHOD;
            cr_reg    <= 1'b0;
            mp_reg    <= '0;
            kind_reg  <= KIND_BOTH;
            empty_reg <= 1'b1;
            len_reg   <= '0;
            body_reg  <= '0;
            keep_reg  <= 1'b0;
            rcv_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            mp_reg    <= mp_next;
            kind_reg  <= kind_next;
            empty_reg <= empty_next;
            len_reg   <= len_next;
            body_reg  <= body_next;
            keep_reg  <= keep_next;
            rcv_reg   <= rcv_next;
        end
    end

    assign result = '{status: status, url_byte_valid: url,
                      keep_alive: keep_next, content_length: len_next};

endmodule

/* hdl/hgp_out_reg.sv */
module hgp_out_reg
    import hgp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  result_t   result,
    output logic      can_load,
    hgp_out_if.source out_item
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_load = !valid_reg || out_item.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_item.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_item.valid          = valid_reg;
    assign out_item.status         = result_reg.status;
    assign out_item.url_byte_valid = result_reg.url_byte_valid;
    assign out_item.keep_alive     = result_reg.keep_alive;
    assign out_item.content_length = result_reg.content_length;

endmodule

/* hdl/http_get_request_parser.sv */
// An item accepted at one clock edge is parsed at the next edge at which the result register
// is free; its result is then offered by the result register until it is taken.
// Throughput: one item per cycle while the result register is free; the byte match, the decimal
// accumulate and the state update all fit in the single logic stage between the two registers.
// Reset (rst_n, asynchronous, active low): both registers empty, parse state back to method
// matching, max_request_bytes back to 2048.
module http_get_request_parser
    import hgp_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_write_en,
    input  logic [CFG_W-1:0] cfg_write_data,
    hgp_in_if.sink           in_item,
    hgp_out_if.source        out_item
);

    // The block is a two-register pipeline. The input register takes one request byte per
    // item. When it holds an item and the result register can take a new value, the parser
    // consumes the byte: its state registers move on and the result item is loaded, all at
    // the same edge. The input register refills at that same edge, so bytes stream at one
    // per cycle as long as results are taken.

    logic    in_valid;
    item_t   item;
    logic    out_can_load;
    logic    step;
    result_t result;

    // A byte moves through the parser only when its result has somewhere to go.
    assign step = in_valid && out_can_load;

    hgp_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_item),
        .take    (step),
        .valid   (in_valid),
        .item    (item)
    );

    // The parser holds the request state: phase, match position, header kind, the CR flag,
    // the blank-line flag, the content length, the body count, the keep-alive flag and the
    // byte count that is checked against the configured limit.
    hgp_parse #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_parse (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .step           (step),
        .item           (item),
        .result         (result)
    );

    hgp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .can_load (out_can_load),
        .out_item (out_item)
    );

    // Every parsed byte leaves a result item behind.
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_item.valid)
        else $error("parsed item produced no result");

    // A byte waiting in the input register is never dropped while the result side stalls.
    a_held_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !step) |=> in_valid)
        else $error("waiting item lost");

    // A path byte is only flagged on a request that is still being parsed.
    a_url_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_item.valid && out_item.url_byte_valid) |-> (out_item.status == ST_PENDING))
        else $error("path byte flagged with a final status");

endmodule
